// ===== rtl/lts_pkg.sv =====
// Shared types, constants and character-class helpers for the token scanner.
package lts_pkg;

    localparam int unsigned MAX_LEXEME_DEF = 32;

    // Keyword spellings, right-aligned, one byte per character
    localparam int unsigned KW_W  = 40;
    localparam int unsigned POS_W = 7;
    localparam logic [KW_W-1:0] KW_IF    = "if";
    localparam logic [KW_W-1:0] KW_ELSE  = "else";
    localparam logic [KW_W-1:0] KW_PRINT = "print";
    localparam logic [2:0] KW_IF_LEN    = 3'd2;
    localparam logic [2:0] KW_ELSE_LEN  = 3'd4;
    localparam logic [2:0] KW_PRINT_LEN = 3'd5;

    typedef enum logic [2:0] {
        KIND_NUMBER   = 3'd0,
        KIND_IDENT    = 3'd1,
        KIND_KEYWORD  = 3'd2,
        KIND_OPERATOR = 3'd3,
        KIND_SPECIAL  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_line;
    } lts_in_t;

    typedef struct packed {
        logic [7:0] token_char;
        logic [2:0] token_kind;
        logic       last_of_token;
        logic       truncated;
    } lts_out_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == ":") || (c == "=") || (c == "<") || (c == ">");
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return (c == ".") || (c == ",") || (c == ";") || (c == "?") || (c == "/") ||
               (c == "|") || (c == "'") || (c == "-") || (c == "_") || (c == "(") ||
               (c == ")") || (c == "[") || (c == "]") || (c == "{") || (c == "}");
    endfunction

    // True when c is the keyword's character at position pos
    function automatic logic kw_step(input logic [KW_W-1:0] word, input logic [2:0] wlen,
                                     input logic [POS_W-1:0] pos, input logic [7:0] c);
        logic [KW_W-1:0] sh;
        sh = '0;
        if (POS_W'(wlen) <= pos) begin
            return 1'b0;
        end
        sh = word >> (8 * (POS_W'(wlen) - pos - POS_W'(1)));
        return sh[7:0] == c;
    endfunction

endpackage

// ===== rtl/lexical_token_scanner_core.sv =====
// Byte-stream tokenizer: sequencer around a lexeme buffer memory.
//
// Usage: one text byte per transfer on s_ (in_byte, end_of_line); one token
// character per transfer on m_, tagged with kind, last_of_token and truncated.
// A number, identifier or lone dot leaves when the byte after it arrives or
// when its line ends; an operator or special leaves right after its own byte.
// Sequence: a byte that extends, starts or skips a token is accepted, then
// scanned; end_of_line adds an EOL step. Ending a number or identifier
// replays the lexeme buffer at one character per cycle while the output is
// not stalled, then rescans the byte that ended it (no rescan at end of line).
// An operator or special is emitted from its own state after the scan; a lone
// dot is emitted, then the byte after it is rescanned.
// The lexeme buffer has a single read/write port; the sequencer never reads
// it while appending, so no forwarding is needed.
// Reset: the scanner returns to idle with an empty lexeme; buffer contents
// are not cleared, as only written entries are ever read back.
// Stall: results go through one output register; while it is full and
// m_ready is low, a state that emits holds and s_ready stays low until the
// transfer completes.
module lexical_token_scanner_core #(
    parameter int unsigned MAX_LEXEME = lts_pkg::MAX_LEXEME_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lts_pkg::lts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lts_pkg::lts_out_t m_data
);
    import lts_pkg::*;

    localparam int unsigned AW = $clog2(MAX_LEXEME);
    localparam int unsigned LW = $clog2(MAX_LEXEME + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SINGLE, S_EOL, S_DOT, S_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        M_IDLE, M_NUM, M_IDENT, M_DOT
    } mode_t;

    state_t         state_reg;
    mode_t          mode_reg;
    logic [7:0]     c_reg;
    logic           eol_reg;
    logic           eol_phase_reg;
    logic [LW-1:0]  len_reg;
    logic           ovf_reg;
    logic           kw_if_reg;
    logic           kw_else_reg;
    logic           kw_print_reg;
    kind_t          kind_reg;
    logic [AW-1:0]  out_idx_reg;
    logic [7:0]     rd_data_reg;
    logic           m_valid_reg;
    lts_out_t       m_data_reg;

    logic [7:0]     lex_mem [MAX_LEXEME];

    logic           out_free;
    logic           emit;
    logic           c_digit;
    logic           c_dot;
    logic           c_word;
    logic           cont;
    logic           starter;
    logic           single;
    kind_t          single_kind;
    logic           do_append;
    logic           mem_we;
    logic           has_room;
    logic           in_token;
    logic           flush_start;
    logic           fl_last;
    logic           mem_re;
    logic [AW-1:0]  rd_addr;
    kind_t          flush_kind;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = out_free && ((state_reg == S_SINGLE) || (state_reg == S_DOT) ||
                                   (state_reg == S_FLUSH));
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign c_digit  = is_digit(c_reg);
    assign c_dot    = (c_reg == ".");
    assign c_word   = is_alpha(c_reg) || (c_reg == "_");
    assign starter  = c_digit || c_dot || c_word;
    assign single   = !starter && (is_operator(c_reg) || is_special(c_reg));
    assign single_kind = is_operator(c_reg) ? KIND_OPERATOR : KIND_SPECIAL;
    assign in_token = (mode_reg == M_NUM) || (mode_reg == M_IDENT);
    assign has_room = (len_reg < LW'(MAX_LEXEME));

    always_comb begin
        unique case (mode_reg)
            M_NUM:   cont = c_digit || c_dot;
            M_IDENT: cont = c_word || c_digit;
            M_DOT:   cont = c_digit;
            default: cont = 1'b0;
        endcase
    end

    assign do_append = (state_reg == S_SCAN) && (cont || ((mode_reg == M_IDLE) && starter));
    assign mem_we    = do_append && has_room;
    assign flush_start = in_token &&
                         (((state_reg == S_SCAN) && !do_append) || (state_reg == S_EOL));
    assign fl_last   = ((LW'(out_idx_reg) + LW'(1)) == len_reg);
    assign mem_re    = flush_start || ((state_reg == S_FLUSH) && out_free && !fl_last);
    assign rd_addr   = flush_start ? '0 : (out_idx_reg + AW'(1));

    always_comb begin
        flush_kind = KIND_IDENT;
        if (mode_reg == M_NUM) begin
            flush_kind = KIND_NUMBER;
        end else if (!ovf_reg &&
                     ((kw_if_reg && (len_reg == LW'(KW_IF_LEN))) ||
                      (kw_else_reg && (len_reg == LW'(KW_ELSE_LEN))) ||
                      (kw_print_reg && (len_reg == LW'(KW_PRINT_LEN))))) begin
            flush_kind = KIND_KEYWORD;
        end
    end

    // Lexeme buffer: one port, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lex_mem[len_reg[AW-1:0]] <= c_reg;
        end
        if (mem_re) begin
            rd_data_reg <= lex_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_IDLE;
            eol_phase_reg <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            kw_if_reg     <= 1'b1;
            kw_else_reg   <= 1'b1;
            kw_print_reg  <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        c_reg     <= s_data.in_byte;
                        eol_reg   <= s_data.end_of_line;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (do_append) begin
                        if (has_room) begin
                            len_reg      <= len_reg + LW'(1);
                            kw_if_reg    <= kw_if_reg &
                                            kw_step(KW_IF, KW_IF_LEN, POS_W'(len_reg), c_reg);
                            kw_else_reg  <= kw_else_reg &
                                            kw_step(KW_ELSE, KW_ELSE_LEN, POS_W'(len_reg), c_reg);
                            kw_print_reg <= kw_print_reg &
                                            kw_step(KW_PRINT, KW_PRINT_LEN, POS_W'(len_reg), c_reg);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if ((mode_reg == M_IDLE) || (mode_reg == M_DOT)) begin
                            if (c_digit) begin
                                mode_reg <= M_NUM;
                            end else if (c_dot) begin
                                mode_reg <= M_DOT;
                            end else begin
                                mode_reg <= M_IDENT;
                            end
                        end
                        state_reg <= eol_reg ? S_EOL : S_IDLE;
                    end else if (in_token) begin
                        kind_reg      <= flush_kind;
                        out_idx_reg   <= '0;
                        eol_phase_reg <= 1'b0;
                        state_reg     <= S_FLUSH;
                    end else if (mode_reg == M_DOT) begin
                        eol_phase_reg <= 1'b0;
                        state_reg     <= S_DOT;
                    end else if (single) begin
                        state_reg <= S_SINGLE;
                    end else begin
                        // skip: whitespace or unknown byte, nothing open
                        state_reg <= S_IDLE;
                    end
                end
                S_SINGLE: begin
                    if (out_free) begin
                        m_data_reg.token_char    <= c_reg;
                        m_data_reg.token_kind    <= single_kind;
                        m_data_reg.last_of_token <= 1'b1;
                        m_data_reg.truncated     <= 1'b0;
                        state_reg                <= S_IDLE;
                    end
                end
                S_EOL: begin
                    eol_phase_reg <= 1'b1;
                    if (in_token) begin
                        kind_reg    <= flush_kind;
                        out_idx_reg <= '0;
                        state_reg   <= S_FLUSH;
                    end else if (mode_reg == M_DOT) begin
                        state_reg <= S_DOT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DOT: begin
                    if (out_free) begin
                        m_data_reg.token_char    <= ".";
                        m_data_reg.token_kind    <= KIND_SPECIAL;
                        m_data_reg.last_of_token <= 1'b1;
                        m_data_reg.truncated     <= 1'b0;
                        mode_reg                 <= M_IDLE;
                        len_reg                  <= '0;
                        ovf_reg                  <= 1'b0;
                        kw_if_reg                <= 1'b1;
                        kw_else_reg              <= 1'b1;
                        kw_print_reg             <= 1'b1;
                        // resume the held byte unless this was the line-end flush
                        state_reg                <= eol_phase_reg ? S_IDLE : S_SCAN;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        m_data_reg.token_char    <= rd_data_reg;
                        m_data_reg.token_kind    <= kind_reg;
                        m_data_reg.last_of_token <= fl_last;
                        m_data_reg.truncated     <= ovf_reg;
                        if (fl_last) begin
                            mode_reg     <= M_IDLE;
                            len_reg      <= '0;
                            ovf_reg      <= 1'b0;
                            kw_if_reg    <= 1'b1;
                            kw_else_reg  <= 1'b1;
                            kw_print_reg <= 1'b1;
                            state_reg    <= eol_phase_reg ? S_IDLE : S_SCAN;
                        end else begin
                            out_idx_reg <= out_idx_reg + AW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_no_write_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH) |-> !mem_we)
        else $error("lexeme buffer written during replay");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_LEXEME))
        else $error("lexeme length past bound");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (len_reg == LW'(MAX_LEXEME)))
        else $error("overflow flagged with buffer not full");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == M_IDLE) |-> ((len_reg == '0) && !ovf_reg))
        else $error("idle scanner holds a lexeme");

    a_replay_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH) |-> ((mode_reg == M_NUM) || (mode_reg == M_IDENT)))
        else $error("replay without an open number or identifier");

endmodule

// ===== dv/tb_lexical_token_scanner_core.sv =====
// Self-checking testbench for the lexical token scanner: random text lines, stalls on both sides.
module tb_lexical_token_scanner_core;
    import lts_pkg::*;

    localparam int unsigned LEX_MAX      = MAX_LEXEME_DEF;
    localparam int unsigned DRAIN_CYCLES = 2 * LEX_MAX + 8;
    // Watchdog limit: covers every text byte and token character with the random waits on both sides
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;

    typedef enum logic [1:0] {
        SCAN_IDLE  = 2'd0,
        SCAN_NUM   = 2'd1,
        SCAN_IDENT = 2'd2,
        SCAN_DOT   = 2'd3
    } scan_state_t;

    typedef struct {
        lts_in_t item;
        bit      hold_for_drain;
    } text_byte_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lts_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lts_out_t m_data;

    text_byte_t  pending_bytes[$];
    lts_out_t    expected_chars[$];

    scan_state_t scan_state = SCAN_IDLE;
    logic [7:0]  lex_buf[LEX_MAX];
    int unsigned lex_len    = 0;
    bit          lex_over   = 1'b0;

    int unsigned errors      = 0;
    int unsigned cycle_count = 0;
    int unsigned bytes_taken = 0;
    int unsigned s_gap       = 0;
    int unsigned m_gap       = 0;
    int unsigned m_hold      = 0;
    bit          s_calm      = 1'b0;
    bit          m_calm      = 1'b0;
    bit          long_hold_done = 1'b0;

    string kw_pool[6] = '{"if", "else", "print", "iff", "els", "Print"};
    string op_chars    = "+-*/:=<>";
    string punct_chars = ".,;?/|'-_()[]{}";
    string junk_chars  = "@#$%!`~^&\"\\";

    lexical_token_scanner_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ---------------- character classes ----------------
    function automatic bit digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit blank_c(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit oper_c(input logic [7:0] c);
        for (int i = 0; i < op_chars.len(); i++) begin
            if (c == op_chars[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit punct_c(input logic [7:0] c);
        for (int i = 0; i < punct_chars.len(); i++) begin
            if (c == punct_chars[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // ---------------- token prediction ----------------
    function automatic bit lexeme_is(input string w);
        if (lex_len != w.len()) return 1'b0;
        for (int i = 0; i < w.len(); i++) begin
            if (lex_buf[i] != w[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_result(input logic [7:0] ch, input kind_t k, input bit last,
                               input bit trunc);
        lts_out_t r;
        r.token_char    = ch;
        r.token_kind    = k;
        r.last_of_token = last;
        r.truncated     = trunc;
        expected_chars.push_back(r);
    endtask

    task automatic keep_char(input logic [7:0] c);
        if (lex_len < LEX_MAX) begin
            lex_buf[lex_len] = c;
            lex_len++;
        end else begin
            lex_over = 1'b1;
        end
    endtask

    task automatic flush_lexeme();
        kind_t k;
        if (scan_state == SCAN_DOT) begin
            push_result(".", KIND_SPECIAL, 1'b1, 1'b0);
        end else if (scan_state == SCAN_NUM || scan_state == SCAN_IDENT) begin
            k = (scan_state == SCAN_NUM) ? KIND_NUMBER : KIND_IDENT;
            // a cut identifier never counts as a keyword
            if (k == KIND_IDENT && !lex_over &&
                (lexeme_is("if") || lexeme_is("else") || lexeme_is("print"))) begin
                k = KIND_KEYWORD;
            end
            for (int i = 0; i < lex_len; i++) begin
                push_result(lex_buf[i], k, (i + 1 == lex_len), lex_over);
            end
        end
        scan_state = SCAN_IDLE;
        lex_len    = 0;
        lex_over   = 1'b0;
    endtask

    task automatic scan_char(input logic [7:0] c);
        if (scan_state == SCAN_NUM) begin
            if (digit_c(c) || c == ".") begin
                keep_char(c);
                return;
            end
            flush_lexeme();
        end else if (scan_state == SCAN_IDENT) begin
            if (letter_c(c) || digit_c(c) || c == "_") begin
                keep_char(c);
                return;
            end
            flush_lexeme();
        end else if (scan_state == SCAN_DOT) begin
            if (digit_c(c)) begin
                scan_state = SCAN_NUM;
                keep_char(c);
                return;
            end
            flush_lexeme();
        end
        if (blank_c(c)) return;
        if (digit_c(c)) begin
            scan_state = SCAN_NUM;
            keep_char(c);
        end else if (c == ".") begin
            scan_state = SCAN_DOT;
            keep_char(c);
        end else if (letter_c(c) || c == "_") begin
            scan_state = SCAN_IDENT;
            keep_char(c);
        end else if (oper_c(c)) begin
            push_result(c, KIND_OPERATOR, 1'b1, 1'b0);
        end else if (punct_c(c)) begin
            push_result(c, KIND_SPECIAL, 1'b1, 1'b0);
        end
    endtask

    task automatic predict_tokens(input lts_in_t it);
        scan_char(it.in_byte);
        if (it.end_of_line) flush_lexeme();
    endtask

    // ---------------- stimulus ----------------
    function automatic int unsigned draw_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(24, 8);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1)) return 8'($urandom_range(122, 97));
        return 8'($urandom_range(90, 65));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(57, 48));
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit eol, input bit drain);
        text_byte_t t;
        t.item.in_byte     = b;
        t.item.end_of_line = eol;
        t.hold_for_drain   = drain;
        pending_bytes.push_back(t);
    endtask

    task automatic push_text(input string s, input bit eol_last, input bit drain);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], eol_last && (i == s.len() - 1), drain && (i == 0));
        end
    endtask

    // One line of random tokens and stray bytes, end_of_line on its last byte
    task automatic add_line(input bit drain, input bit force_long);
        logic [7:0]  text[$];
        int unsigned ntok, r, n, sel;
        string       w;
        ntok = $urandom_range(6, 1);
        for (int t = 0; t < ntok; t++) begin
            r = $urandom_range(99);
            if (force_long && t == 0) r = 96 + $urandom_range(3);
            if (r < 22) begin
                if ($urandom_range(4) == 0) text.push_back(".");
                text.push_back(rand_digit());
                n = $urandom_range(5);
                repeat (n) text.push_back(($urandom_range(5) == 0) ? 8'h2e : rand_digit());
            end else if (r < 44) begin
                text.push_back(($urandom_range(5) == 0) ? 8'h5f : rand_letter());
                n = $urandom_range(6);
                repeat (n) begin
                    sel = $urandom_range(5);
                    text.push_back(sel == 0 ? 8'h5f : (sel == 1 ? rand_digit() : rand_letter()));
                end
            end else if (r < 56) begin
                w = kw_pool[$urandom_range(5)];
                for (int i = 0; i < w.len(); i++) text.push_back(w[i]);
            end else if (r < 68) begin
                text.push_back(op_chars[$urandom_range(op_chars.len() - 1)]);
            end else if (r < 78) begin
                text.push_back(punct_chars[$urandom_range(punct_chars.len() - 1)]);
            end else if (r < 84) begin
                text.push_back(".");
            end else if (r < 96) begin
                sel = $urandom_range(4);
                case (sel)
                    0: text.push_back(8'($urandom_range(255, 128)));
                    1: text.push_back(8'($urandom_range(8, 0)));
                    2: text.push_back(8'($urandom_range(31, 14)));
                    3: text.push_back(8'd127);
                    default: text.push_back(junk_chars[$urandom_range(junk_chars.len() - 1)]);
                endcase
            end else begin
                // lexeme past the buffer bound
                n = $urandom_range(LEX_MAX + 8, LEX_MAX + 1);
                if ($urandom_range(1)) begin
                    w = "print";
                    for (int i = 0; i < n; i++) text.push_back(i < 5 ? w[i] : rand_letter());
                end else begin
                    for (int i = 0; i < n; i++) begin
                        text.push_back(($urandom_range(7) == 0) ? 8'h2e : rand_digit());
                    end
                end
            end
            sel = $urandom_range(9);
            if (sel >= 6 && sel < 9) text.push_back(" ");
            else if (sel == 9) text.push_back(8'($urandom_range(13, 9)));
        end
        for (int i = 0; i < text.size(); i++) begin
            push_byte(text[i], i == text.size() - 1, drain && i == 0);
        end
    endtask

    task automatic add_noise();
        int unsigned n;
        n = $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
            push_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(3) == 0), 1'b0);
        end
    endtask

    // ---------------- input driver ----------------
    always @(posedge aclk) begin : drive_input
        text_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
                bytes_taken++;
            end
            if ($urandom_range(79) == 0) s_calm = !s_calm;
            // hold the payload until the transfer completes
            if (!(s_valid && !s_ready)) begin
                if (s_gap != 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() != 0 &&
                             !(pending_bytes[0].hold_for_drain && expected_chars.size() != 0)) begin
                    nxt = pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= nxt.item;
                    s_gap = draw_gap(s_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- long receiver stall ----------------
    // back-pressure long enough to fill the block and stall its input
    always @(posedge aclk) begin : long_stall
        if (!aresetn) begin
            m_hold <= 0;
        end else if (!long_hold_done && bytes_taken >= 200) begin
            long_hold_done <= 1'b1;
            m_hold         <= 400;
        end else if (m_hold != 0) begin
            m_hold <= m_hold - 1;
        end
    end

    // ---------------- result monitor ----------------
    always @(posedge aclk) begin : watch_output
        lts_out_t want;
        bit       rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    errors++;
                    $error("unexpected token character %h", m_data.token_char);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.token_char !== want.token_char) begin
                        errors++;
                        $error("token_char: expected %h, got %h",
                               want.token_char, m_data.token_char);
                    end
                    if (m_data.token_kind !== want.token_kind) begin
                        errors++;
                        $error("token_kind: expected %0d, got %0d",
                               want.token_kind, m_data.token_kind);
                    end
                    if (m_data.last_of_token !== want.last_of_token) begin
                        errors++;
                        $error("last_of_token: expected %b, got %b",
                               want.last_of_token, m_data.last_of_token);
                    end
                    if (m_data.truncated !== want.truncated) begin
                        errors++;
                        $error("truncated: expected %b, got %b",
                               want.truncated, m_data.truncated);
                    end
                end
                m_gap = draw_gap(m_calm);
            end
            if ($urandom_range(79) == 0) m_calm = !m_calm;
            if (m_hold != 0) begin
                rdy = 1'b0;
            end else if (m_gap != 0) begin
                m_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : run_test
        int unsigned line_no;
        // directed lines
        push_text("if;", 1'b1, 1'b0);
        push_text(".5. ._/-", 1'b1, 1'b0);
        push_text("print=", 1'b1, 1'b0);
        push_text(".", 1'b1, 1'b0);
        push_byte("9", 1'b0, 1'b1);
        push_byte(8'hff, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h09, 1'b1, 1'b0);
        // random lines, first two with oversized lexemes
        add_line(1'b0, 1'b1);
        add_line(1'b0, 1'b1);
        line_no = 0;
        while (pending_bytes.size() < 440) begin
            if ($urandom_range(9) == 0) add_noise();
            else add_line(line_no % 25 == 24, 1'b0);
            line_no++;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_chars.size() != 0) begin
            errors++;
            $error("%0d token characters never arrived", expected_chars.size());
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
